// File: hdl/particle_sensor_uart_sequencer_macros.svh
// assertion macros shared by the sequencer
`ifndef PARTICLE_SENSOR_UART_SEQUENCER_MACROS_SVH
`define PARTICLE_SENSOR_UART_SEQUENCER_MACROS_SVH

// same-cycle implication, held off while reset is low
`define PSUS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while reset is low
`define PSUS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/psus_pkg.sv
`default_nettype none

package psus_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_POLL_INTERVAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLY_TIMEOUT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_OFF_TIME = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_TIME    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_GAP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_WAIT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT    = 3'd6;

    // reply bytes kept for parsing
    localparam int RX_KEEP = 10;

    localparam logic [7:0] ACK_BYTE   = 8'hA5;
    localparam logic [7:0] HDR_BYTE0  = 8'h40;
    localparam logic [7:0] HDR_BYTE1  = 8'h05;
    localparam logic [7:0] HDR_BYTE2  = 8'h04;

    typedef enum logic [1:0] {
        FR_AUTOSTOP = 2'd0,
        FR_STOP     = 2'd1,
        FR_START    = 2'd2,
        FR_READ     = 2'd3
    } t_frame;

    typedef struct packed {
        logic [15:0] poll_interval;
        logic [15:0] reply_timeout;
        logic [15:0] power_off_time;
        logic [15:0] warmup_time;
        logic [15:0] command_gap;
        logic [15:0] error_wait;
        logic [7:0]  retry_limit;
    } t_cfg;

    typedef struct packed {
        logic        sensor_power;
        logic [15:0] pm2_5_value;
        logic [15:0] pm10_value;
        logic        reading_valid;
        logic        error_flag;
        logic [31:0] fault_count;
        logic [31:0] recovery_count;
    } t_status;

    typedef struct packed {
        logic   send;
        t_frame frame;
    } t_tx_req;

    function automatic logic [7:0] frame_byte(t_frame fr, logic [1:0] beat);
        logic [7:0] b;
        case (beat)
            2'd0: b = 8'h68;
            2'd1: b = 8'h01;
            2'd2: begin
                case (fr)
                    FR_AUTOSTOP: b = 8'h20;
                    FR_STOP:     b = 8'h02;
                    FR_START:    b = 8'h01;
                    FR_READ:     b = 8'h04;
                    default:     b = 8'h00;
                endcase
            end
            default: begin
                case (fr)
                    FR_AUTOSTOP: b = 8'h77;
                    FR_STOP:     b = 8'h95;
                    FR_START:    b = 8'h96;
                    FR_READ:     b = 8'h93;
                    default:     b = 8'h00;
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: hdl/psus_in_if.sv
`default_nettype none

interface psus_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: hdl/psus_out_if.sv
`default_nettype none

interface psus_out_if;
    logic        valid;
    logic        ready;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        last;
    logic        sensor_power;
    logic [15:0] pm2_5_value;
    logic [15:0] pm10_value;
    logic        reading_valid;
    logic        error_flag;
    logic [31:0] fault_count;
    logic [31:0] recovery_count;

    modport source (
        output valid, output tx_valid, output tx_byte, output last, output sensor_power,
        output pm2_5_value, output pm10_value, output reading_valid, output error_flag,
        output fault_count, output recovery_count, input ready
    );
    modport sink (
        input valid, input tx_valid, input tx_byte, input last, input sensor_power,
        input pm2_5_value, input pm10_value, input reading_valid, input error_flag,
        input fault_count, input recovery_count, output ready
    );
endinterface

`default_nettype wire

// File: hdl/particle_sensor_uart_sequencer.sv
// Particle sensor serial-link sequencer. Each input item is a millisecond tick
// (command 0) or a byte received from the sensor (command 1); it updates the
// sequencer state in the cycle it is accepted. An item that sends no frame gives
// one result, with last set; an item that starts a command frame gives four
// results carrying the frame bytes in order, all showing the status after that
// item. One item is taken per cycle while results are taken at once and no
// frame is sent; after a frame item the output stage sends its four bytes and
// the next item enters with the fourth. Configuration registers are written
// through i_cfg_we/i_cfg_idx/i_cfg_data; the user must write only while the
// block is idle (unchecked); an index past the retry limit register is ignored.
`default_nettype none

`include "particle_sensor_uart_sequencer_macros.svh"

module particle_sensor_uart_sequencer #(
    parameter int RX_MAX_BYTES = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [psus_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [psus_pkg::CFG_DATA_W-1:0] i_cfg_data,
    psus_in_if.sink                             i_in,
    psus_out_if.source                          o_out
);
    import psus_pkg::*;

    t_cfg    cfg;
    t_status status_next;
    t_tx_req tx_req;
    logic    in_ready;
    logic    accept;
    logic    out_fire;
    logic    tx_busy;
    logic    mid_frame;
    logic    both_flags;

    assign i_in.ready = in_ready;
    assign accept     = i_in.valid && in_ready;

    psus_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    psus_core #(
        .RX_MAX_BYTES (RX_MAX_BYTES)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_command (i_in.command),
        .i_rx_byte (i_in.rx_byte),
        .i_cfg     (cfg),
        .o_status  (status_next),
        .o_tx      (tx_req)
    );

    psus_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_status (status_next),
        .i_tx     (tx_req),
        .o_ready  (in_ready),
        .o_out    (o_out)
    );

    assign out_fire   = o_out.valid && o_out.ready;
    assign tx_busy    = o_out.valid && o_out.tx_valid;
    assign mid_frame  = tx_busy && !o_out.last;
    assign both_flags = o_out.reading_valid && o_out.error_flag;

    // a frame in flight keeps going until its fourth byte
    `PSUS_ASSERT_NEXT(a_frame_continues, out_fire && mid_frame, tx_busy, "frame cut short")
    // no item enters while a frame byte other than the last is pending
    `PSUS_ASSERT_NOW(a_no_accept_mid_frame, mid_frame, !i_in.ready, "item taken mid frame")
    // a good reading is only possible once the error has been cleared
    `PSUS_ASSERT_NOW(a_valid_excludes_error, o_out.valid, !both_flags, "valid with error")

endmodule

`default_nettype wire

// File: hdl/psus_cfg_regs.sv
`default_nettype none

module psus_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [psus_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [psus_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output psus_pkg::t_cfg                       o_cfg
);
    import psus_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poll_interval  <= 16'd1000;
            r_cfg.reply_timeout  <= 16'd100;
            r_cfg.power_off_time <= 16'd1000;
            r_cfg.warmup_time    <= 16'd500;
            r_cfg.command_gap    <= 16'd100;
            r_cfg.error_wait     <= 16'd1000;
            r_cfg.retry_limit    <= 8'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POLL_INTERVAL:  r_cfg.poll_interval  <= i_cfg_data;
                CFG_REPLY_TIMEOUT:  r_cfg.reply_timeout  <= i_cfg_data;
                CFG_POWER_OFF_TIME: r_cfg.power_off_time <= i_cfg_data;
                CFG_WARMUP_TIME:    r_cfg.warmup_time    <= i_cfg_data;
                CFG_COMMAND_GAP:    r_cfg.command_gap    <= i_cfg_data;
                CFG_ERROR_WAIT:     r_cfg.error_wait     <= i_cfg_data;
                CFG_RETRY_LIMIT:    r_cfg.retry_limit    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: hdl/psus_core.sv
`default_nettype none

module psus_core #(
    parameter int RX_MAX_BYTES = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic             i_command,
    input  wire logic [7:0]       i_rx_byte,
    input  wire psus_pkg::t_cfg   i_cfg,
    output psus_pkg::t_status     o_status,
    output psus_pkg::t_tx_req     o_tx
);
    import psus_pkg::*;

    localparam int LW = $clog2(RX_MAX_BYTES + 1);

    typedef enum logic [3:0] {
        PH_POWER_OFF = 4'd0,
        PH_AS_GAP    = 4'd1,
        PH_AS_REPLY  = 4'd2,
        PH_ST_GAP    = 4'd3,
        PH_ST_REPLY  = 4'd4,
        PH_SR_GAP    = 4'd5,
        PH_SR_REPLY  = 4'd6,
        PH_RD_GAP    = 4'd7,
        PH_RD_REPLY  = 4'd8,
        PH_ERR_WAIT  = 4'd9
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_timer, n_timer;
    logic [7:0]  r_retry, n_retry;
    logic [LW-1:0] r_rxlen, n_rxlen;
    logic [7:0]  r_bytes [RX_KEEP];
    logic [7:0]  n_bytes [RX_KEEP];
    logic [15:0] r_pm25, n_pm25;
    logic [15:0] r_pm10, n_pm10;
    logic        r_valid, n_valid;
    logic        r_err, n_err;
    logic [31:0] r_errcnt, n_errcnt;
    logic [31:0] r_recov, n_recov;
    logic        r_power, n_power;

    logic [15:0]   timer_inc;
    logic [LW-1:0] rd_next;
    logic [LW-1:0] rd_len;
    logic          wr_en;
    logic [3:0]    wr_idx;
    logic          cmd_done, cmd_ok, rd_done;
    logic          hdr10, hdr8, rd_good;
    logic [7:0]    sum10, sum8;
    t_tx_req       tx;

    assign timer_inc = (r_timer == 16'hFFFF) ? r_timer : r_timer + 16'd1;
    assign rd_next   = r_rxlen + LW'(1);

    // reply parsing works on the bytes as they stand after this item
    assign sum10 = n_bytes[2] + n_bytes[3] + n_bytes[4] + n_bytes[5]
                 + n_bytes[6] + n_bytes[7] + n_bytes[8] + n_bytes[9];
    assign sum8  = n_bytes[0] + n_bytes[1] + n_bytes[2] + n_bytes[3]
                 + n_bytes[4] + n_bytes[5] + n_bytes[6] + n_bytes[7];
    assign hdr10 = (rd_len == LW'(10)) && (n_bytes[2] == HDR_BYTE0)
                 && (n_bytes[3] == HDR_BYTE1) && (n_bytes[4] == HDR_BYTE2);
    assign hdr8  = (rd_len == LW'(8)) && (n_bytes[0] == HDR_BYTE0)
                 && (n_bytes[1] == HDR_BYTE1) && (n_bytes[2] == HDR_BYTE2);
    assign rd_good = (hdr10 && (sum10 == 8'd0)) || (hdr8 && (sum8 == 8'd0));

    // byte capture into the reply buffer
    always_comb begin
        wr_en  = 1'b0;
        wr_idx = 4'd0;
        rd_len = r_rxlen;
        if (i_accept && i_command) begin
            case (r_phase)
                PH_AS_REPLY, PH_ST_REPLY, PH_SR_REPLY: begin
                    wr_en  = 1'b1;
                    wr_idx = {3'd0, r_rxlen[0]};
                end
                PH_RD_REPLY: begin
                    wr_en  = (r_rxlen < LW'(RX_KEEP));
                    wr_idx = r_rxlen[3:0];
                    rd_len = rd_next;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < RX_KEEP; i++) begin
            n_bytes[i] = (wr_en && (wr_idx == 4'(i))) ? i_rx_byte : r_bytes[i];
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_timer  = r_timer;
        n_retry  = r_retry;
        n_rxlen  = r_rxlen;
        n_pm25   = r_pm25;
        n_pm10   = r_pm10;
        n_valid  = r_valid;
        n_err    = r_err;
        n_errcnt = r_errcnt;
        n_recov  = r_recov;
        n_power  = r_power;
        cmd_done = 1'b0;
        cmd_ok   = 1'b0;
        rd_done  = 1'b0;
        tx.send  = 1'b0;
        tx.frame = FR_AUTOSTOP;

        if (i_accept) begin
            if (!i_command) begin
                n_timer = timer_inc;
                case (r_phase)
                    PH_POWER_OFF: begin
                        n_power = 1'b0;
                        if (timer_inc >= i_cfg.power_off_time) begin
                            n_power = 1'b1;
                            n_retry = 8'd0;
                            n_timer = 16'd0;
                            n_phase = PH_AS_GAP;
                        end
                    end
                    PH_AS_GAP: begin
                        if (timer_inc >= i_cfg.warmup_time) begin
                            tx.send  = 1'b1;
                            tx.frame = FR_AUTOSTOP;
                            n_timer  = 16'd0;
                            n_rxlen  = '0;
                            n_phase  = PH_AS_REPLY;
                        end
                    end
                    PH_ST_GAP: begin
                        if (timer_inc >= i_cfg.command_gap) begin
                            tx.send  = 1'b1;
                            tx.frame = FR_STOP;
                            n_timer  = 16'd0;
                            n_rxlen  = '0;
                            n_phase  = PH_ST_REPLY;
                        end
                    end
                    PH_SR_GAP: begin
                        if (timer_inc >= i_cfg.command_gap) begin
                            tx.send  = 1'b1;
                            tx.frame = FR_START;
                            n_timer  = 16'd0;
                            n_rxlen  = '0;
                            n_phase  = PH_SR_REPLY;
                        end
                    end
                    PH_RD_GAP: begin
                        if (timer_inc >= i_cfg.poll_interval) begin
                            tx.send  = 1'b1;
                            tx.frame = FR_READ;
                            n_timer  = 16'd0;
                            n_rxlen  = '0;
                            n_phase  = PH_RD_REPLY;
                        end
                    end
                    PH_AS_REPLY, PH_ST_REPLY, PH_SR_REPLY: begin
                        if (timer_inc >= i_cfg.reply_timeout) begin
                            cmd_done = 1'b1;
                        end
                    end
                    PH_RD_REPLY: begin
                        if (timer_inc >= i_cfg.reply_timeout) begin
                            rd_done = 1'b1;
                        end
                    end
                    PH_ERR_WAIT: begin
                        if (timer_inc >= i_cfg.error_wait) begin
                            n_power = 1'b0;
                            n_timer = 16'd0;
                            n_phase = PH_POWER_OFF;
                        end
                    end
                    default: begin
                        n_power = 1'b0;
                        n_timer = 16'd0;
                        n_rxlen = '0;
                        n_phase = PH_POWER_OFF;
                    end
                endcase
            end else begin
                case (r_phase)
                    PH_AS_REPLY, PH_ST_REPLY, PH_SR_REPLY: begin
                        // ack is two bytes, decided on the second
                        n_rxlen = LW'({1'b0, r_rxlen[0]}) + LW'(1);
                        if (r_rxlen[0]) begin
                            cmd_done = 1'b1;
                            cmd_ok   = (r_bytes[0] == ACK_BYTE) && (i_rx_byte == ACK_BYTE);
                        end
                    end
                    PH_RD_REPLY: begin
                        n_rxlen = rd_next;
                        if (rd_next >= LW'(RX_MAX_BYTES)) begin
                            rd_done = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end

            if (cmd_done) begin
                n_rxlen = '0;
                if (r_phase == PH_AS_REPLY) begin
                    if (cmd_ok) begin
                        n_err   = 1'b0;
                        n_recov = r_recov + 32'd1;
                        n_timer = 16'd0;
                        n_phase = PH_ST_GAP;
                    end else if (r_retry < i_cfg.retry_limit) begin
                        n_retry = r_retry + 8'd1;
                        n_timer = 16'd0;
                        n_phase = PH_AS_GAP;
                    end else begin
                        n_errcnt = r_err ? r_errcnt : r_errcnt + 32'd1;
                        n_err    = 1'b1;
                        n_valid  = 1'b0;
                        n_timer  = 16'd0;
                        n_phase  = PH_ERR_WAIT;
                    end
                end else if (cmd_ok) begin
                    n_timer = 16'd0;
                    n_phase = (r_phase == PH_ST_REPLY) ? PH_SR_GAP : PH_RD_GAP;
                end else begin
                    n_errcnt = r_err ? r_errcnt : r_errcnt + 32'd1;
                    n_err    = 1'b1;
                    n_valid  = 1'b0;
                    n_timer  = 16'd0;
                    n_phase  = PH_ERR_WAIT;
                end
            end

            if (rd_done) begin
                n_rxlen = '0;
                if (rd_good) begin
                    n_pm25  = hdr10 ? {n_bytes[5], n_bytes[6]} : {n_bytes[3], n_bytes[4]};
                    n_pm10  = hdr10 ? {n_bytes[7], n_bytes[8]} : {n_bytes[5], n_bytes[6]};
                    n_valid = 1'b1;
                    n_timer = 16'd0;
                    n_phase = PH_RD_GAP;
                end else begin
                    n_errcnt = r_err ? r_errcnt : r_errcnt + 32'd1;
                    n_err    = 1'b1;
                    n_valid  = 1'b0;
                    n_timer  = 16'd0;
                    n_phase  = PH_ERR_WAIT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
        if (!i_rst_n) begin
            r_phase  <= PH_POWER_OFF;
            r_timer  <= 16'd0;
            r_retry  <= 8'd0;
            r_rxlen  <= '0;
            r_pm25   <= 16'd0;
            r_pm10   <= 16'd0;
            r_valid  <= 1'b0;
            r_err    <= 1'b0;
            r_errcnt <= 32'd0;
            r_recov  <= 32'd0;
            r_power  <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_timer  <= n_timer;
            r_retry  <= n_retry;
            r_rxlen  <= n_rxlen;
            r_pm25   <= n_pm25;
            r_pm10   <= n_pm10;
            r_valid  <= n_valid;
            r_err    <= n_err;
            r_errcnt <= n_errcnt;
            r_recov  <= n_recov;
            r_power  <= n_power;
        end
    end

    always_comb begin
        o_status.sensor_power   = n_power;
        o_status.pm2_5_value    = n_pm25;
        o_status.pm10_value     = n_pm10;
        o_status.reading_valid  = n_valid;
        o_status.error_flag     = n_err;
        o_status.fault_count    = n_errcnt;
        o_status.recovery_count = n_recov;
    end

    assign o_tx = tx;

endmodule

`default_nettype wire

// File: hdl/psus_out_stage.sv
`default_nettype none

module psus_out_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire psus_pkg::t_status  i_status,
    input  wire psus_pkg::t_tx_req  i_tx,
    output logic                    o_ready,
    psus_out_if.source              o_out
);
    import psus_pkg::*;

    logic       r_valid;
    logic       r_tx;
    logic [1:0] r_beat;
    t_frame     r_frame;
    t_status    r_status;
    logic       last_beat;

    assign last_beat = !r_tx || (r_beat == 2'd3);
    // a new item may enter as the final result of the previous one leaves
    assign o_ready   = !r_valid || (o_out.ready && last_beat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tx    <= 1'b0;
            r_beat  <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_tx    <= i_tx.send;
            r_beat  <= 2'd0;
        end else if (r_valid && o_out.ready) begin
            if (last_beat) begin
                r_valid <= 1'b0;
            end else begin
                r_beat <= r_beat + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_frame  <= i_tx.frame;
            r_status <= i_status;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.tx_valid       = r_tx;
    assign o_out.tx_byte        = r_tx ? frame_byte(r_frame, r_beat) : 8'd0;
    assign o_out.last           = last_beat;
    assign o_out.sensor_power   = r_status.sensor_power;
    assign o_out.pm2_5_value    = r_status.pm2_5_value;
    assign o_out.pm10_value     = r_status.pm10_value;
    assign o_out.reading_valid  = r_status.reading_valid;
    assign o_out.error_flag     = r_status.error_flag;
    assign o_out.fault_count    = r_status.fault_count;
    assign o_out.recovery_count = r_status.recovery_count;

endmodule

`default_nettype wire

// File: tb/sv/tb_particle_sensor_uart_sequencer.sv
module tb_particle_sensor_uart_sequencer;
    import psus_pkg::*;

    localparam int RX_MAX        = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 36;
    localparam int LONG_ITEMS    = 24;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_BYTE = 1'b1;

    localparam logic [7:0] FRAME_TAB [0:3][0:3] = '{
        '{8'h68, 8'h01, 8'h20, 8'h77},
        '{8'h68, 8'h01, 8'h02, 8'h95},
        '{8'h68, 8'h01, 8'h01, 8'h96},
        '{8'h68, 8'h01, 8'h04, 8'h93}
    };

    typedef enum logic [3:0] {
        SQ_POWER_OFF = 4'd0,
        SQ_AS_GAP    = 4'd1,
        SQ_AS_REPLY  = 4'd2,
        SQ_ST_GAP    = 4'd3,
        SQ_ST_REPLY  = 4'd4,
        SQ_SR_GAP    = 4'd5,
        SQ_SR_REPLY  = 4'd6,
        SQ_RD_GAP    = 4'd7,
        SQ_RD_REPLY  = 4'd8,
        SQ_ERR_WAIT  = 4'd9
    } seq_phase_e;

    typedef struct packed {
        seq_phase_e      phase;
        logic [15:0]     timer;
        logic [7:0]      retries;
        logic [4:0]      rx_len;
        logic [9:0][7:0] rx_buf;
        logic [15:0]     pm25;
        logic [15:0]     pm10;
        logic            valid;
        logic            err;
        logic            power;
        logic [31:0]     err_cnt;
        logic [31:0]     recov_cnt;
    } seq_state_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
    } sensor_item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       last;
        t_status    status;
    } out_beat_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  drv_valid = 1'b0;
    logic                  drv_cmd   = 1'b0;
    logic [7:0]            drv_byte  = '0;
    logic                  mon_ready = 1'b0;

    psus_in_if  in_if();
    psus_out_if out_if();

    assign in_if.valid   = drv_valid;
    assign in_if.command = drv_cmd;
    assign in_if.rx_byte = drv_byte;
    assign out_if.ready  = mon_ready;

    particle_sensor_uart_sequencer #(
        .RX_MAX_BYTES(RX_MAX)
    ) u_top (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_in      (in_if.sink),
        .o_out     (out_if.source)
    );

    always #5 clk = ~clk;

    t_cfg         cfg_now;
    seq_state_t   mirror_st;
    seq_state_t   plan_st;
    sensor_item_t items_to_send [$];
    out_beat_t    beats_due [$];

    bit idle_on;
    int send_gap;
    int recv_stall;
    int plan_pushed;
    int mismatches;
    int items_sent;
    int beats_seen;
    int frames_seen;
    int cycle_count;

    sensor_item_t acc_item;
    sensor_item_t nxt_item;
    t_frame       acc_frame;
    bit           acc_sent;
    t_status      acc_status;
    out_beat_t    acc_beat;
    out_beat_t    want;
    out_beat_t    got;
    int           k;

    // ---------------- sequencer predictor ----------------

    function automatic void seq_enter_error(inout seq_state_t s);
        if (!s.err) s.err_cnt = s.err_cnt + 32'd1;
        s.err   = 1'b1;
        s.valid = 1'b0;
        s.timer = '0;
        s.phase = SQ_ERR_WAIT;
    endfunction

    function automatic void seq_command_done(inout seq_state_t s, input t_cfg c, input bit ok);
        s.rx_len = '0;
        if (s.phase == SQ_AS_REPLY) begin
            if (ok) begin
                s.err       = 1'b0;
                s.recov_cnt = s.recov_cnt + 32'd1;
                s.timer     = '0;
                s.phase     = SQ_ST_GAP;
            end else if (s.retries < c.retry_limit) begin
                s.retries = s.retries + 8'd1;
                s.timer   = '0;
                s.phase   = SQ_AS_GAP;
            end else begin
                seq_enter_error(s);
            end
        end else if (ok) begin
            s.timer = '0;
            s.phase = (s.phase == SQ_ST_REPLY) ? SQ_SR_GAP : SQ_RD_GAP;
        end else begin
            seq_enter_error(s);
        end
    endfunction

    function automatic void seq_read_done(inout seq_state_t s);
        int         n;
        int         base;
        bit         hdr;
        logic [7:0] sum;
        n        = s.rx_len;
        s.rx_len = '0;
        hdr      = 1'b0;
        base     = 0;
        if (n == 10 && s.rx_buf[2] == HDR_BYTE0 && s.rx_buf[3] == HDR_BYTE1
                && s.rx_buf[4] == HDR_BYTE2) begin
            hdr  = 1'b1;
            base = 2;
        end else if (n == 8 && s.rx_buf[0] == HDR_BYTE0 && s.rx_buf[1] == HDR_BYTE1
                && s.rx_buf[2] == HDR_BYTE2) begin
            hdr = 1'b1;
        end
        if (hdr) begin
            sum = '0;
            for (int i = 0; i < 8; i++) sum = sum + s.rx_buf[base + i];
            if (sum == 8'h00) begin
                s.pm25  = {s.rx_buf[base + 3], s.rx_buf[base + 4]};
                s.pm10  = {s.rx_buf[base + 5], s.rx_buf[base + 6]};
                s.valid = 1'b1;
                s.timer = '0;
                s.phase = SQ_RD_GAP;
                return;
            end
        end
        seq_enter_error(s);
    endfunction

    // returns 1 when the item sends a frame
    function automatic bit seq_advance(inout seq_state_t s, input t_cfg c,
                                       input sensor_item_t it, output t_frame fr);
        bit sent;
        int n;
        sent = 1'b0;
        fr   = FR_READ;
        if (it.cmd == CMD_TICK) begin
            if (s.timer != 16'hFFFF) s.timer = s.timer + 16'd1;
            case (s.phase)
                SQ_POWER_OFF: begin
                    s.power = 1'b0;
                    if (s.timer >= c.power_off_time) begin
                        s.power   = 1'b1;
                        s.retries = '0;
                        s.timer   = '0;
                        s.phase   = SQ_AS_GAP;
                    end
                end
                SQ_AS_GAP: if (s.timer >= c.warmup_time) begin
                    sent    = 1'b1;
                    fr      = FR_AUTOSTOP;
                    s.phase = SQ_AS_REPLY;
                end
                SQ_ST_GAP: if (s.timer >= c.command_gap) begin
                    sent    = 1'b1;
                    fr      = FR_STOP;
                    s.phase = SQ_ST_REPLY;
                end
                SQ_SR_GAP: if (s.timer >= c.command_gap) begin
                    sent    = 1'b1;
                    fr      = FR_START;
                    s.phase = SQ_SR_REPLY;
                end
                SQ_RD_GAP: if (s.timer >= c.poll_interval) begin
                    sent    = 1'b1;
                    fr      = FR_READ;
                    s.phase = SQ_RD_REPLY;
                end
                SQ_AS_REPLY, SQ_ST_REPLY, SQ_SR_REPLY: begin
                    if (s.timer >= c.reply_timeout) seq_command_done(s, c, 1'b0);
                end
                SQ_RD_REPLY: begin
                    if (s.timer >= c.reply_timeout) seq_read_done(s);
                end
                SQ_ERR_WAIT: begin
                    if (s.timer >= c.error_wait) begin
                        s.power = 1'b0;
                        s.timer = '0;
                        s.phase = SQ_POWER_OFF;
                    end
                end
                default: begin
                    s.power  = 1'b0;
                    s.timer  = '0;
                    s.rx_len = '0;
                    s.phase  = SQ_POWER_OFF;
                end
            endcase
            // a frame opens a fresh reply window
            if (sent) begin
                s.timer  = '0;
                s.rx_len = '0;
            end
        end else begin
            if (s.phase == SQ_AS_REPLY || s.phase == SQ_ST_REPLY || s.phase == SQ_SR_REPLY) begin
                n           = s.rx_len & 5'd1;
                s.rx_buf[n] = it.data;
                s.rx_len    = 5'(n + 1);
                if (s.rx_len == 5'd2)
                    seq_command_done(s, c, s.rx_buf[0] == ACK_BYTE && s.rx_buf[1] == ACK_BYTE);
            end else if (s.phase == SQ_RD_REPLY) begin
                n = s.rx_len;
                if (n < 10) s.rx_buf[n] = it.data;
                n        = n + 1;
                s.rx_len = 5'(n);
                if (n >= RX_MAX) seq_read_done(s);
            end
        end
        return sent;
    endfunction

    // ---------------- stimulus planning ----------------

    function automatic void plan_push(input logic cmd, input logic [7:0] data);
        sensor_item_t it;
        t_frame       fr;
        bit           sent;
        it.cmd  = cmd;
        it.data = data;
        items_to_send.push_back(it);
        plan_pushed++;
        sent = seq_advance(plan_st, cfg_now, it, fr);
    endfunction

    function automatic void plan_ticks_through(input seq_phase_e ph);
        while (plan_st.phase == ph) plan_push(CMD_TICK, 8'($urandom));
    endfunction

    function automatic void plan_command_reply();
        seq_phase_e ph;
        int         r;
        ph = plan_st.phase;
        r  = $urandom_range(0, 9);
        if (r < 6) begin
            plan_push(CMD_BYTE, ACK_BYTE);
            plan_push(CMD_BYTE, ACK_BYTE);
        end else if (r == 6) begin
            plan_push(CMD_BYTE, 8'($urandom));
            plan_push(CMD_BYTE, ACK_BYTE);
        end else if (r == 7) begin
            plan_push(CMD_BYTE, ACK_BYTE);
            plan_push(CMD_BYTE, 8'($urandom));
        end else begin
            // a lone byte or silence, then the window runs out
            if (r == 9) plan_push(CMD_BYTE, 8'($urandom));
            plan_ticks_through(ph);
        end
    endfunction

    function automatic void plan_read_reply();
        logic [9:0][7:0] msg;
        logic [7:0]      sum;
        int              len;
        int              base;
        int              r;
        int              j;
        r = $urandom_range(0, 9);
        for (int i = 0; i < 10; i++) msg[i] = 8'($urandom);
        if (r < 7) begin
            len  = ($urandom_range(0, 1) == 0) ? 8 : 10;
            base = len - 8;
            msg[base]     = HDR_BYTE0;
            msg[base + 1] = HDR_BYTE1;
            msg[base + 2] = HDR_BYTE2;
            sum = '0;
            for (int i = 0; i < 7; i++) sum = sum + msg[base + i];
            msg[base + 7] = 8'h00 - sum;
            if ($urandom_range(0, 4) == 0) begin
                j      = $urandom_range(0, len - 1);
                msg[j] = msg[j] ^ (8'h01 << $urandom_range(0, 7));
            end
        end else if (r == 7) begin
            len = $urandom_range(0, RX_MAX - 1);
        end else if (r == 8) begin
            len = RX_MAX;
        end else begin
            len = 0;
        end
        for (int i = 0; i < len && plan_st.phase == SQ_RD_REPLY; i++)
            plan_push(CMD_BYTE, (i < 10) ? msg[i] : 8'($urandom));
        plan_ticks_through(SQ_RD_REPLY);
    endfunction

    function automatic void plan_random(input int count);
        int base;
        int strays;
        base   = plan_pushed;
        strays = 0;
        while (plan_pushed - base - strays < count) begin
            case (plan_st.phase)
                SQ_AS_REPLY, SQ_ST_REPLY, SQ_SR_REPLY: plan_command_reply();
                SQ_RD_REPLY: plan_read_reply();
                default: begin
                    if ($urandom_range(0, 11) == 0) begin
                        plan_push(CMD_BYTE, 8'($urandom));
                        strays++;
                    end else begin
                        plan_push(CMD_TICK, 8'($urandom));
                    end
                end
            endcase
        end
    endfunction

    function automatic logic [15:0] pick_ms();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'd1;
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [15:0] pick_retry_word();
        logic [7:0] lim;
        case ($urandom_range(0, 5))
            0:       lim = 8'd0;
            1:       lim = 8'd255;
            default: lim = 8'($urandom_range(0, 3));
        endcase
        return {8'($urandom), lim};
    endfunction

    // ---------------- configuration ----------------

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_POLL_INTERVAL:  cfg_now.poll_interval  = data;
            CFG_REPLY_TIMEOUT:  cfg_now.reply_timeout  = data;
            CFG_POWER_OFF_TIME: cfg_now.power_off_time = data;
            CFG_WARMUP_TIME:    cfg_now.warmup_time    = data;
            CFG_COMMAND_GAP:    cfg_now.command_gap    = data;
            CFG_ERROR_WAIT:     cfg_now.error_wait     = data;
            CFG_RETRY_LIMIT:    cfg_now.retry_limit    = data[7:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [15:0] poll, input logic [15:0] reply,
                             input logic [15:0] poff, input logic [15:0] warm,
                             input logic [15:0] gap, input logic [15:0] errw,
                             input logic [15:0] retry_word);
        write_reg(CFG_POLL_INTERVAL, poll);
        write_reg(CFG_REPLY_TIMEOUT, reply);
        write_reg(CFG_POWER_OFF_TIME, poff);
        write_reg(CFG_WARMUP_TIME, warm);
        write_reg(CFG_COMMAND_GAP, gap);
        write_reg(CFG_ERROR_WAIT, errw);
        write_reg(CFG_RETRY_LIMIT, retry_word);
    endtask

    task automatic wait_idle();
        while (items_to_send.size() != 0 || drv_valid || beats_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
            mismatches++;
        end
    endfunction

    // ---------------- driver ----------------

    always @(posedge clk) begin
        if (!rst_n) begin
            drv_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (drv_valid && in_if.ready) begin
                acc_item.cmd  = drv_cmd;
                acc_item.data = drv_byte;
                acc_sent = seq_advance(mirror_st, cfg_now, acc_item, acc_frame);
                acc_status.sensor_power   = mirror_st.power;
                acc_status.pm2_5_value    = mirror_st.pm25;
                acc_status.pm10_value     = mirror_st.pm10;
                acc_status.reading_valid  = mirror_st.valid;
                acc_status.error_flag     = mirror_st.err;
                acc_status.fault_count    = mirror_st.err_cnt;
                acc_status.recovery_count = mirror_st.recov_cnt;
                for (k = 0; k < (acc_sent ? 4 : 1); k++) begin
                    acc_beat.tx_valid = acc_sent;
                    acc_beat.tx_byte  = acc_sent ? FRAME_TAB[int'(acc_frame)][k] : 8'h00;
                    acc_beat.last     = acc_sent ? (k == 3) : 1'b1;
                    acc_beat.status   = acc_status;
                    beats_due.push_back(acc_beat);
                end
                items_sent++;
            end
            if (!drv_valid || in_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    drv_valid <= 1'b0;
                end else if (items_to_send.size() != 0) begin
                    nxt_item = items_to_send.pop_front();
                    drv_valid <= 1'b1;
                    drv_cmd   <= nxt_item.cmd;
                    drv_byte  <= nxt_item.data;
                    if (idle_on && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 13);
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk) begin
        if (!rst_n) begin
            mon_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (out_if.valid && mon_ready) begin
                got.tx_valid              = out_if.tx_valid;
                got.tx_byte               = out_if.tx_byte;
                got.last                  = out_if.last;
                got.status.sensor_power   = out_if.sensor_power;
                got.status.pm2_5_value    = out_if.pm2_5_value;
                got.status.pm10_value     = out_if.pm10_value;
                got.status.reading_valid  = out_if.reading_valid;
                got.status.error_flag     = out_if.error_flag;
                got.status.fault_count    = out_if.fault_count;
                got.status.recovery_count = out_if.recovery_count;
                if (beats_due.size() == 0) begin
                    $error("result arrived with no item waiting for it");
                    mismatches++;
                end else begin
                    want = beats_due.pop_front();
                    check_field("tx_valid", want.tx_valid, got.tx_valid);
                    check_field("tx_byte", want.tx_byte, got.tx_byte);
                    check_field("last", want.last, got.last);
                    check_field("sensor_power", want.status.sensor_power,
                                got.status.sensor_power);
                    check_field("pm2_5_value", want.status.pm2_5_value, got.status.pm2_5_value);
                    check_field("pm10_value", want.status.pm10_value, got.status.pm10_value);
                    check_field("reading_valid", want.status.reading_valid,
                                got.status.reading_valid);
                    check_field("error_flag", want.status.error_flag, got.status.error_flag);
                    check_field("fault_count", want.status.fault_count, got.status.fault_count);
                    check_field("recovery_count", want.status.recovery_count,
                                got.status.recovery_count);
                end
                beats_seen++;
                if (got.tx_valid && got.last) frames_seen++;
            end
            if (recv_stall > 0) begin
                recv_stall--;
                mon_ready <= 1'b0;
            end else begin
                mon_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0) recv_stall = $urandom_range(1, 13);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------- sequence of phases ----------------

    initial begin
        cfg_now = '{poll_interval: 16'd1000, reply_timeout: 16'd100, power_off_time: 16'd1000,
                    warmup_time: 16'd500, command_gap: 16'd100, error_wait: 16'd1000,
                    retry_limit: 8'd10};
        mirror_st = '0;
        plan_st   = '0;
        idle_on   = 1'b1;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // short timers, zero values behave like one, a single autosend retry
        write_all(16'd1, 16'd2, 16'd1, 16'd0, 16'd0, 16'd1, 16'd1);
        @(negedge clk);
        plan_push(CMD_BYTE, 8'hFF);         // stray byte while unpowered
        plan_push(CMD_TICK, 8'h00);         // power on
        plan_push(CMD_TICK, 8'hFF);         // autosend stop frame
        plan_push(CMD_TICK, 8'h00);
        plan_push(CMD_TICK, 8'h00);         // reply timeout, retry
        plan_push(CMD_TICK, 8'h00);         // autosend stop again
        plan_push(CMD_BYTE, ACK_BYTE);
        plan_push(CMD_BYTE, 8'h5A);         // bad ack, retries used up
        plan_push(CMD_TICK, 8'h00);         // error wait over
        plan_push(CMD_TICK, 8'h00);         // power on
        plan_push(CMD_TICK, 8'h00);         // autosend stop
        plan_push(CMD_BYTE, ACK_BYTE);
        plan_push(CMD_BYTE, ACK_BYTE);      // recovery
        plan_push(CMD_TICK, 8'h00);         // stop frame
        plan_push(CMD_BYTE, ACK_BYTE);
        plan_push(CMD_BYTE, ACK_BYTE);
        plan_push(CMD_TICK, 8'h00);         // start frame
        plan_push(CMD_BYTE, ACK_BYTE);
        plan_push(CMD_BYTE, ACK_BYTE);
        plan_push(CMD_TICK, 8'h00);         // read frame
        plan_push(CMD_BYTE, HDR_BYTE0);
        plan_push(CMD_BYTE, HDR_BYTE1);
        plan_push(CMD_BYTE, HDR_BYTE2);
        plan_push(CMD_BYTE, 8'hFF);
        plan_push(CMD_BYTE, 8'hFF);
        plan_push(CMD_BYTE, 8'hFF);
        plan_push(CMD_BYTE, 8'hFF);
        plan_push(CMD_BYTE, 8'hBB);
        plan_push(CMD_TICK, 8'h00);
        plan_push(CMD_TICK, 8'h00);         // reply accepted at timeout
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_all(pick_ms(), pick_ms(), pick_ms(), pick_ms(), pick_ms(), pick_ms(),
                      pick_retry_word());
            idle_on = ($urandom_range(0, 3) != 0);
            @(negedge clk);
            plan_random(PHASE_ITEMS);
            wait_idle();
        end

        // widest timers, full-scale register data, no idling
        idle_on = 1'b0;
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        @(negedge clk);
        for (int i = 0; i < LONG_ITEMS; i++) begin
            if ($urandom_range(0, 3) == 0) plan_push(CMD_BYTE, 8'($urandom));
            else plan_push(CMD_TICK, 8'($urandom));
        end
        wait_idle();

        $display("covered %0d sensor items, %0d result beats and %0d command frames",
                 items_sent, beats_seen, frames_seen);
        $display("sequencer entered error %0d times and recovered %0d times",
                 mirror_st.err_cnt, mirror_st.recov_cnt);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/psus_pkg.sv
hdl/psus_in_if.sv
hdl/psus_out_if.sv
hdl/psus_cfg_regs.sv
hdl/psus_core.sv
hdl/psus_out_stage.sv
hdl/particle_sensor_uart_sequencer.sv
tb/sv/tb_particle_sensor_uart_sequencer.sv
